// ----- rtl/affra_pkg.sv -----
// Shared types and constants for the first-fit atlas rectangle allocator.
// Depends on nothing; imported by the allocator top level.
package affra_pkg;

   localparam int unsigned COORD_W       = 13;
   localparam int unsigned MAX_RECTS_DEF = 64;
   localparam int unsigned MAX_SIDE      = 4096;
   localparam logic [COORD_W-1:0] ATLAS_RESET = 13'd1024;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [0:0] {
      CSR_ATLAS_WIDTH  = 1'b0,
      CSR_ATLAS_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] l;
      logic [COORD_W-1:0] b;
      logic [COORD_W-1:0] r;
      logic [COORD_W-1:0] t;
   } rect_type;

   // limit an atlas side to the largest supported side
   function automatic logic [COORD_W-1:0] clamp_side(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] res;
      res = v;
      if (32'(v) > MAX_SIDE) begin
         res = COORD_W'(MAX_SIDE);
      end
      return res;
   endfunction

endpackage

// ----- rtl/affra_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module affra_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/atlas_first_fit_rect_allocator_top.sv -----
// First-fit rectangle allocator for a 2D atlas: sequencer, valid bits and config.
// Depends on affra_pkg and affra_ram.
//
// A transaction enters when start is high while busy is low. An add request
// (req_opcode 0) places a size_w by size_h rectangle at the first corner found
// scanning rows upward and then columns rightward, inside the atlas and clear of
// every stored rectangle; a remove request (req_opcode 1) deletes every stored
// rectangle with exactly the given corner and size. Exactly one result comes back
// per transaction as a one-cycle strobe on rsp_valid with rsp_ok and the placed
// edges (zero on failure and on remove). The receiver cannot stall: sample the
// result in the cycle rsp_valid is high. Rectangles live in a MAX_RECTS-entry
// table memory read one entry per cycle; valid bits sit in flops, so reset needs
// no clearing pass and the block is ready right after reset. A remove sweeps the
// table once. An add first scans the valid bits for the lowest free entry, then
// visits MAX_RECTS + 1 candidate rows and, for each row still worth trying,
// sweeps the table once per shift of the candidate corner, one entry at a time
// through the table's single read port. Write atlas_width and atlas_height only
// while busy is low.
module atlas_first_fit_rect_allocator_top
   import affra_pkg::*;
#(
   parameter int unsigned MAX_RECTS = MAX_RECTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic [COORD_W-1:0] req_pos_x,
   input  logic [COORD_W-1:0] req_pos_y,
   input  logic [COORD_W-1:0] req_size_w,
   input  logic [COORD_W-1:0] req_size_h,
   // response channel
   output logic               rsp_valid,
   output logic               rsp_ok,
   output logic [COORD_W-1:0] rsp_left,
   output logic [COORD_W-1:0] rsp_bottom,
   output logic [COORD_W-1:0] rsp_right,
   output logic [COORD_W-1:0] rsp_top,
   // configuration
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [COORD_W-1:0] csr_wdata
);

   localparam int unsigned IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_RECTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RECTS - 1);
   localparam logic [CNT_W-1:0] LAST_CAND = CNT_W'(MAX_RECTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SLOT,
      S_CAND,
      S_CAND_WAIT,
      S_FX_START,
      S_FX_SCAN,
      S_WRITE,
      S_RM_SCAN
   } state_type;

   // control state
   state_type            state_ff,  state_in;
   logic [MAX_RECTS-1:0] valid_ff,  valid_in;
   logic [IDX_W-1:0]     scan_ff,   scan_in;
   logic [IDX_W-1:0]     slot_ff,   slot_in;
   logic [CNT_W-1:0]     cand_ff,   cand_in;
   logic                 moved_ff,  moved_in;
   logic                 found_ff,  found_in;
   logic                 any_ff,    any_in;
   logic [COORD_W-1:0]   aw_ff,     aw_in;
   logic [COORD_W-1:0]   ah_ff,     ah_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   logic                 op_ff,     op_in;
   logic [COORD_W-1:0]   px_ff,     px_in;
   logic [COORD_W-1:0]   py_ff,     py_in;
   logic [COORD_W-1:0]   w_ff,      w_in;
   logic [COORD_W-1:0]   h_ff,      h_in;
   logic [COORD_W-1:0]   x_ff,      x_in;
   logic [COORD_W-1:0]   y_ff,      y_in;
   logic [COORD_W-1:0]   best_x_ff, best_x_in;
   logic [COORD_W-1:0]   best_y_ff, best_y_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [COORD_W-1:0]   rsp_left_ff,   rsp_left_in;
   logic [COORD_W-1:0]   rsp_bottom_ff, rsp_bottom_in;
   logic [COORD_W-1:0]   rsp_right_ff,  rsp_right_in;
   logic [COORD_W-1:0]   rsp_top_ff,    rsp_top_in;

   // table memory
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   rect_type         ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   rect_type         ram_rd_data;

   affra_ram #(
      .WIDTH ($bits(rect_type)),
      .DEPTH (MAX_RECTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // clamped atlas size and shared sums
   logic [COORD_W-1:0] aw_c, ah_c;
   logic [COORD_W:0]   x_plus_w, y_plus_h, px_plus_w, py_plus_h;
   logic [CNT_W-1:0]   cand_m1;

   assign aw_c      = clamp_side(aw_ff);
   assign ah_c      = clamp_side(ah_ff);
   assign x_plus_w  = {1'b0, x_ff} + {1'b0, w_ff};
   assign y_plus_h  = {1'b0, y_ff} + {1'b0, h_ff};
   assign px_plus_w = {1'b0, px_ff} + {1'b0, w_ff};
   assign py_plus_h = {1'b0, py_ff} + {1'b0, h_ff};
   assign cand_m1   = cand_ff - CNT_W'(1);

   always_comb begin
      logic               adv_cand;
      logic               eval_en;
      logic [COORD_W-1:0] eval_y;
      logic [COORD_W:0]   eval_top;
      logic               hit;
      logic               match;
      logic [COORD_W-1:0] x_next;
      logic               moved_next;
      logic               any_next;
      logic               respond;
      logic               resp_ok;

      adv_cand   = 1'b0;
      eval_en    = 1'b0;
      eval_y     = '0;
      eval_top   = '0;
      hit        = 1'b0;
      match      = 1'b0;
      x_next     = x_ff;
      moved_next = moved_ff;
      any_next   = any_ff;
      respond    = 1'b0;
      resp_ok    = 1'b0;

      state_in   = state_ff;
      valid_in   = valid_ff;
      scan_in    = scan_ff;
      slot_in    = slot_ff;
      cand_in    = cand_ff;
      moved_in   = moved_ff;
      found_in   = found_ff;
      any_in     = any_ff;
      aw_in      = aw_ff;
      ah_in      = ah_ff;
      op_in      = op_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      best_x_in  = best_x_ff;
      best_y_in  = best_y_ff;

      rsp_valid_in  = 1'b0;
      rsp_ok_in     = rsp_ok_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_bottom_in = rsp_bottom_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_top_in    = rsp_top_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_ff;
      ram_wr_data.l = best_x_ff;
      ram_wr_data.b = best_y_ff;
      ram_wr_data.r = COORD_W'({1'b0, best_x_ff} + {1'b0, w_ff});
      ram_wr_data.t = COORD_W'({1'b0, best_y_ff} + {1'b0, h_ff});
      ram_rd_en   = 1'b0;
      ram_rd_addr = scan_ff + IDX_W'(1);

      // config writes must be made only while idle; the block itself does not enforce it
      if (csr_we) begin
         case (csr_index)
            CSR_ATLAS_WIDTH:  aw_in = csr_wdata;
            CSR_ATLAS_HEIGHT: ah_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = req_opcode;
               px_in   = req_pos_x;
               py_in   = req_pos_y;
               w_in    = req_size_w;
               h_in    = req_size_h;
               scan_in = '0;
               any_in  = 1'b0;
               if (req_opcode == OP_REMOVE) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  state_in    = S_RM_SCAN;
               end else begin
                  state_in = S_SLOT;
               end
            end
         end

         // find the lowest free entry
         S_SLOT: begin
            if (!valid_ff[scan_ff]) begin
               slot_in  = scan_ff;
               cand_in  = '0;
               found_in = 1'b0;
               state_in = S_CAND;
            end else if (scan_ff == LAST_IDX) begin
               respond = 1'b1;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end

         // candidate row: zero, or the top of a stored rectangle
         S_CAND: begin
            if (cand_ff == '0) begin
               eval_en = 1'b1;
               eval_y  = '0;
            end else if (valid_ff[cand_m1[IDX_W-1:0]]) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cand_m1[IDX_W-1:0];
               state_in    = S_CAND_WAIT;
            end else begin
               adv_cand = 1'b1;
            end
         end

         S_CAND_WAIT: begin
            eval_en = 1'b1;
            eval_y  = ram_rd_data.t;
         end

         // bounds check, then sweep the table for this corner
         S_FX_START: begin
            if (x_ff >= aw_c || x_plus_w > {1'b0, aw_c}) begin
               adv_cand = 1'b1;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               scan_in     = '0;
               moved_in    = 1'b0;
               state_in    = S_FX_SCAN;
            end
         end

         S_FX_SCAN: begin
            hit = valid_ff[scan_ff]
                  && (y_ff < ram_rd_data.t)
                  && (y_plus_h > {1'b0, ram_rd_data.b})
                  && (x_ff < ram_rd_data.r)
                  && (x_plus_w > {1'b0, ram_rd_data.l});
            x_next     = hit ? ram_rd_data.r : x_ff;
            moved_next = moved_ff | hit;
            if (scan_ff == LAST_IDX) begin
               if (moved_next) begin
                  x_in     = x_next;
                  state_in = S_FX_START;
               end else begin
                  found_in  = 1'b1;
                  best_x_in = x_ff;
                  best_y_in = y_ff;
                  adv_cand  = 1'b1;
               end
            end else begin
               ram_rd_en = 1'b1;
               scan_in   = scan_ff + IDX_W'(1);
               x_in      = x_next;
               moved_in  = moved_next;
            end
         end

         S_WRITE: begin
            ram_wr_en         = 1'b1;
            valid_in[slot_ff] = 1'b1;
            respond           = 1'b1;
            resp_ok           = 1'b1;
         end

         S_RM_SCAN: begin
            match = valid_ff[scan_ff]
                    && (ram_rd_data.l == px_ff)
                    && (ram_rd_data.b == py_ff)
                    && ({1'b0, ram_rd_data.r} == px_plus_w)
                    && ({1'b0, ram_rd_data.t} == py_plus_h);
            any_next = any_ff | match;
            if (match) begin
               valid_in[scan_ff] = 1'b0;
            end
            any_in = any_next;
            if (scan_ff == LAST_IDX) begin
               respond = 1'b1;
               resp_ok = any_next;
            end else begin
               ram_rd_en = 1'b1;
               scan_in   = scan_ff + IDX_W'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // drop rows outside the atlas or no lower than the best row so far
      if (eval_en) begin
         eval_top = {1'b0, eval_y} + {1'b0, h_ff};
         if (eval_y >= ah_c || eval_top > {1'b0, ah_c} || (found_ff && eval_y >= best_y_ff)) begin
            adv_cand = 1'b1;
         end else begin
            y_in     = eval_y;
            x_in     = '0;
            state_in = S_FX_START;
         end
      end

      // advance to the next candidate row, or finish the add
      if (adv_cand) begin
         if (cand_ff == LAST_CAND) begin
            if (found_ff || found_in) begin
               state_in = S_WRITE;
            end else begin
               respond = 1'b1;
            end
         end else begin
            cand_in  = cand_ff + CNT_W'(1);
            state_in = S_CAND;
         end
      end

      if (respond) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         rsp_ok_in    = resp_ok;
         if (resp_ok && op_ff == OP_ADD) begin
            rsp_left_in   = ram_wr_data.l;
            rsp_bottom_in = ram_wr_data.b;
            rsp_right_in  = ram_wr_data.r;
            rsp_top_in    = ram_wr_data.t;
         end else begin
            rsp_left_in   = '0;
            rsp_bottom_in = '0;
            rsp_right_in  = '0;
            rsp_top_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         scan_ff      <= '0;
         slot_ff      <= '0;
         cand_ff      <= '0;
         moved_ff     <= 1'b0;
         found_ff     <= 1'b0;
         any_ff       <= 1'b0;
         aw_ff        <= ATLAS_RESET;
         ah_ff        <= ATLAS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         scan_ff      <= scan_in;
         slot_ff      <= slot_in;
         cand_ff      <= cand_in;
         moved_ff     <= moved_in;
         found_ff     <= found_in;
         any_ff       <= any_in;
         aw_ff        <= aw_in;
         ah_ff        <= ah_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      best_x_ff     <= best_x_in;
      best_y_ff     <= best_y_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_bottom_ff <= rsp_bottom_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_top_ff    <= rsp_top_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_ok     = rsp_ok_ff;
   assign rsp_left   = rsp_left_ff;
   assign rsp_bottom = rsp_bottom_ff;
   assign rsp_right  = rsp_right_ff;
   assign rsp_top    = rsp_top_ff;

`ifndef SYNTHESIS
   // a result only follows a cycle of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a transaction in flight");

   // an accepted transaction occupies the block
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // a placement only lands in a free entry
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !valid_ff[slot_ff])
      else $error("table write over a live entry");

   // a placed rectangle lies inside the clamped atlas
   a_place_inside: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (ram_wr_data.r <= aw_c && ram_wr_data.t <= ah_c))
      else $error("placed rectangle crosses the atlas edge");

   // a successful add reports the entry just written
   a_add_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok && op_ff == OP_ADD) |-> valid_ff[slot_ff])
      else $error("successful add left its entry invalid");
`endif

endmodule
